// File: hw/rtl/lhs_pkg.sv
package lhs_pkg;

  localparam int MAX_LABELS_DEF = 1024;
  localparam int CNT_W = 11;
  localparam int IDX_W = 10;
  localparam int QDEPTH = 4;
  localparam int QAW = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
  localparam logic [9:0] NTR_MAX = 10'd1023;

  typedef struct packed {
    logic signed [10:0] label;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [10:0] component_total;
    logic [9:0]  nontrivial_total;
    logic [10:0] largest_size;
    logic [10:0] unassigned_total;
  } out_t;

  typedef struct packed {
    logic             neg;
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx;
  } item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

// File: hw/rtl/lhs_ram.sv
module lhs_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/lhs_front.sv
module lhs_front #(
  parameter int MAX_LABELS = lhs_pkg::MAX_LABELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  lhs_pkg::in_t   in_data,
  output logic           head_valid,
  output lhs_pkg::item_t head,
  input  logic           pop
);

  lhs_pkg::item_t              q_r [lhs_pkg::QDEPTH];
  logic [lhs_pkg::QAW-1:0]     wp_r, wp_nxt;
  logic [lhs_pkg::QAW-1:0]     rp_r, rp_nxt;
  logic [lhs_pkg::QAW:0]       cnt_r, cnt_nxt;
  lhs_pkg::item_t              cls;
  logic                        push;
  logic                        do_pop;

  always_comb begin
    cls.neg  = in_data.label[10];
    cls.idx  = in_data.label[lhs_pkg::IDX_W-1:0];
    cls.last = in_data.last;
    cls.hit  = !in_data.label[10] && (32'(cls.idx) < MAX_LABELS);
  end

  assign in_ready   = (cnt_r != (lhs_pkg::QAW+1)'(lhs_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = q_r[rp_r];
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// File: hw/rtl/lhs_back.sv
module lhs_back #(
  parameter int MAX_LABELS = lhs_pkg::MAX_LABELS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  lhs_pkg::item_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output lhs_pkg::out_t  out_data
);

  localparam int AW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_LABELS - 1);

  lhs_pkg::state_t           state_r, state_nxt;
  logic [AW-1:0]             cnt_r, cnt_nxt;
  logic                      pend_r, pend_nxt;
  logic [AW-1:0]             pend_addr_r, pend_addr_nxt;
  logic [AW-1:0]             item_addr_r, item_addr_nxt;
  logic                      item_last_r, item_last_nxt;
  logic [lhs_pkg::CNT_W-1:0] unas_r, unas_nxt;
  logic [10:0]               comps_r, comps_nxt;
  logic [9:0]                ntr_r, ntr_nxt;
  logic [10:0]               big_r, big_nxt;
  logic                      out_valid_r, out_valid_nxt;
  lhs_pkg::out_t             out_data_r, out_data_nxt;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [lhs_pkg::CNT_W-1:0] wdata;
  logic [AW-1:0]             raddr;
  logic [lhs_pkg::CNT_W-1:0] rdata;

  lhs_ram #(
    .WIDTH (lhs_pkg::CNT_W),
    .DEPTH (MAX_LABELS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    item_addr_nxt = item_addr_r;
    item_last_nxt = item_last_r;
    unas_nxt      = unas_r;
    comps_nxt     = comps_r;
    ntr_nxt       = ntr_r;
    big_nxt       = big_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    we            = 1'b0;
    waddr         = item_addr_r;
    wdata         = '0;
    raddr         = AW'(head.idx);

    if ((state_r == lhs_pkg::ST_SCAN || state_r == lhs_pkg::ST_DRAIN) && pend_r) begin
      we    = 1'b1;
      waddr = pend_addr_r;
      wdata = '0;
      if (rdata != '0) begin
        comps_nxt = (comps_r == 11'd2047) ? comps_r : comps_r + 11'd1;
        if (rdata > 11'd1) begin
          ntr_nxt = (ntr_r == lhs_pkg::NTR_MAX) ? ntr_r : ntr_r + 10'd1;
        end
        if (rdata > big_r) begin
          big_nxt = rdata;
        end
      end
    end

    unique case (state_r)
      lhs_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = cnt_r;
        wdata   = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = lhs_pkg::ST_IDLE;
        end
      end
      lhs_pkg::ST_IDLE: begin
        if (head_valid) begin
          pop           = 1'b1;
          item_addr_nxt = AW'(head.idx);
          item_last_nxt = head.last;
          if (head.neg) begin
            unas_nxt = (unas_r == lhs_pkg::CNT_MAX) ? unas_r : unas_r + 1'b1;
          end
          if (head.hit) begin
            state_nxt = lhs_pkg::ST_RMW;
          end else if (head.last) begin
            state_nxt = lhs_pkg::ST_SCAN;
          end
        end
      end
      lhs_pkg::ST_RMW: begin
        we        = 1'b1;
        waddr     = item_addr_r;
        wdata     = (rdata == lhs_pkg::CNT_MAX) ? rdata : rdata + 1'b1;
        state_nxt = item_last_r ? lhs_pkg::ST_SCAN : lhs_pkg::ST_IDLE;
      end
      lhs_pkg::ST_SCAN: begin
        raddr         = cnt_r;
        pend_nxt      = 1'b1;
        pend_addr_nxt = cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = lhs_pkg::ST_DRAIN;
        end
      end
      lhs_pkg::ST_DRAIN: begin
        pend_nxt  = 1'b0;
        state_nxt = lhs_pkg::ST_EMIT;
      end
      lhs_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.component_total  = comps_r;
          out_data_nxt.nontrivial_total = ntr_r;
          out_data_nxt.largest_size     = big_r;
          out_data_nxt.unassigned_total = unas_r;
          comps_nxt                     = '0;
          ntr_nxt                       = '0;
          big_nxt                       = '0;
          unas_nxt                      = '0;
          state_nxt                     = lhs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lhs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lhs_pkg::ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      unas_r      <= '0;
      comps_r     <= '0;
      ntr_r       <= '0;
      big_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      unas_r      <= unas_nxt;
      comps_r     <= comps_nxt;
      ntr_r       <= ntr_nxt;
      big_r       <= big_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    item_addr_r <= item_addr_nxt;
    item_last_r <= item_last_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// File: hw/rtl/label_histogram_summary.sv
// In the back end a counted beat passes through IDLE (RAM read) and RMW (write back of the
// count) before the next beat is popped; an unassigned or out-of-range beat is handled in IDLE.
// A beat arriving at an empty queue is stored in the queue, popped in IDLE and counted in RMW.
// A set's last beat is followed by a scan of every count RAM entry before the summary appears.
// A four-entry queue keeps accepting beats during the scan and while a result waits.
// Reset (rst_n, synchronous) starts a clearing pass over every entry of the count RAM;
// beats are queued but not counted until it finishes.
module label_histogram_summary #(
  parameter int MAX_LABELS = lhs_pkg::MAX_LABELS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  lhs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lhs_pkg::out_t out_data
);

  logic           head_valid;
  lhs_pkg::item_t head;
  logic           pop;

  lhs_front #(
    .MAX_LABELS (MAX_LABELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  lhs_back #(
    .MAX_LABELS (MAX_LABELS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: hw/rtl/lhs_checker.sv
module lhs_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input lhs_pkg::out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before acceptance");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  a_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.component_total >= 11'(out_data.nontrivial_total)) &&
                  ((out_data.largest_size == '0) == (out_data.component_total == '0)))
    else $error("inconsistent summary fields");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("reset did not empty the block");

endmodule

bind label_histogram_summary lhs_checker u_lhs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/tb_label_histogram_summary.sv
class histogram_board;
  int unsigned label_tally[lhs_pkg::MAX_LABELS_DEF];
  int unsigned unassigned_tally;
  lhs_pkg::out_t pending_summaries[$];
  int unsigned mismatches;

  function new();
    clear_set();
    mismatches = 0;
  endfunction

  function void clear_set();
    foreach (label_tally[i]) label_tally[i] = 0;
    unassigned_tally = 0;
  endfunction

  function void count_beat(lhs_pkg::in_t beat);
    lhs_pkg::out_t summary;
    int unsigned comps;
    int unsigned nontriv;
    int unsigned largest;
    if (beat.label[10]) begin
      if (unassigned_tally < lhs_pkg::CNT_MAX) unassigned_tally++;
    end else if (int'(beat.label) < lhs_pkg::MAX_LABELS_DEF) begin
      if (label_tally[int'(beat.label)] < lhs_pkg::CNT_MAX) label_tally[int'(beat.label)]++;
    end
    if (!beat.last) return;
    comps = 0;
    nontriv = 0;
    largest = 0;
    foreach (label_tally[i]) begin
      if (label_tally[i] != 0) begin
        if (comps < lhs_pkg::CNT_MAX) comps++;
        if (label_tally[i] > 1 && nontriv < lhs_pkg::NTR_MAX) nontriv++;
        if (label_tally[i] > largest) largest = label_tally[i];
      end
    end
    summary.component_total = 11'(comps);
    summary.nontrivial_total = 10'(nontriv);
    summary.largest_size = 11'(largest);
    summary.unassigned_total = 11'(unassigned_tally);
    pending_summaries.push_back(summary);
    clear_set();
  endfunction

  function void compare_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_summary(lhs_pkg::out_t got);
    lhs_pkg::out_t want;
    if (pending_summaries.size() == 0) begin
      mismatches++;
      $display("%0t: summary expected none, got %0d %0d %0d %0d", $time,
               got.component_total, got.nontrivial_total, got.largest_size,
               got.unassigned_total);
      return;
    end
    want = pending_summaries.pop_front();
    compare_field("component_total", want.component_total, got.component_total);
    compare_field("nontrivial_total", {1'b0, want.nontrivial_total},
                  {1'b0, got.nontrivial_total});
    compare_field("largest_size", want.largest_size, got.largest_size);
    compare_field("unassigned_total", want.unassigned_total, got.unassigned_total);
  endfunction
endclass

module tb_label_histogram_summary;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SCAN_CYCLES = lhs_pkg::MAX_LABELS_DEF + 3;
  localparam int unsigned IDLE_PCT = 27;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  lhs_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  lhs_pkg::out_t out_data;
  bit calm;
  int unsigned cycles = 0;
  histogram_board board;

  label_histogram_summary i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.check_summary(out_data);
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_beat(logic signed [10:0] label, bit last);
    lhs_pkg::in_t beat;
    beat.label = label;
    beat.last = last;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    board.count_beat(beat);
  endtask

  task automatic send_random_set(int unsigned len);
    logic signed [10:0] label;
    int unsigned base;
    int unsigned kind;
    base = $urandom_range(lhs_pkg::MAX_LABELS_DEF - 16);
    for (int unsigned n = 1; n <= len; n++) begin
      kind = $urandom_range(99);
      if (kind < 20) begin
        label = {1'b1, 10'($urandom)};
      end else if (kind < 70) begin
        label = 11'(base + $urandom_range(15));
      end else begin
        label = {1'b0, 10'($urandom)};
      end
      send_beat(label, n == len);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned sets;
    int unsigned len;
    board = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    calm <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // A set holding only an unassigned vertex leaves the scan empty.
    send_beat(11'h7FF, 1'b1);
    send_beat(11'sd0, 1'b0);
    send_beat(11'sd1023, 1'b0);
    send_beat(11'h400, 1'b0);
    send_beat(11'sd0, 1'b0);
    send_beat(11'sd1023, 1'b1);
    send_beat(11'sd512, 1'b1);
    send_beat(11'sd5, 1'b0);
    send_beat(11'sd5, 1'b0);
    send_beat(11'sd5, 1'b0);
    send_beat(11'h555, 1'b0);
    send_beat(11'sd682, 1'b0);
    send_beat(11'h7FF, 1'b0);
    send_beat(11'sd7, 1'b1);
    send_beat(11'sd0, 1'b1);

    sent = 15;
    sets = 0;
    while (sent < 1250 || sets < 40) begin
      if ($urandom_range(19) == 0) len = $urandom_range(200, 41);
      else len = $urandom_range(40, 1);
      calm <= (sets >= 12 && sets < 18);
      send_random_set(len);
      sent += len;
      sets++;
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    while (board.pending_summaries.size() != 0) @(posedge clk);
    repeat (SCAN_CYCLES + 16) @(posedge clk);
    if (board.mismatches == 0 && board.pending_summaries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/lhs_pkg.sv
hw/rtl/lhs_ram.sv
hw/rtl/lhs_front.sv
hw/rtl/lhs_back.sv
hw/rtl/label_histogram_summary.sv
hw/rtl/lhs_checker.sv
tb/tb_label_histogram_summary.sv
